// ===== design/selective_repeat_sender_window_macros.svh =====
// Assertion macros used by the checker file.
`ifndef SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH
`define SELECTIVE_REPEAT_SENDER_WINDOW_MACROS_SVH

// Check a property while out of reset.
`define SRSW_ASSERT(lbl, clk_s, rst_s, prop) \
  lbl: assert property (@(posedge clk_s) disable iff (!rst_s) prop) \
    else $error("srsw check failed");

// Check a property at every edge, reset included.
`define SRSW_ASSERT_ALWAYS(lbl, clk_s, prop) \
  lbl: assert property (@(posedge clk_s) prop) \
    else $error("srsw check failed");

`endif

// ===== design/srsw_pkg.sv =====
package srsw_pkg;

  localparam int unsigned WINDOW  = 8;
  localparam int unsigned SLOT_W  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned CNT_W   = $clog2(WINDOW + 1);
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned Q_DEPTH = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_PACKET_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS = 2'd1;

  localparam logic [1:0] CMD_TICK  = 2'd0;
  localparam logic [1:0] CMD_ACK   = 2'd1;
  localparam logic [1:0] CMD_START = 2'd2;

  localparam logic ACT_NEW  = 1'b0;
  localparam logic ACT_RETX = 1'b1;

  localparam logic [CFG_W-1:0] TIMEOUT_RESET = 16'd3;

  typedef enum logic [1:0] {
    OP_NOP,
    OP_TICK,
    OP_ACK,
    OP_START
  } op_t;

  typedef struct packed {
    logic [1:0]       command;
    logic [SEQ_W-1:0] ack_seq;
  } in_t;

  typedef struct packed {
    logic             action;
    logic [SEQ_W-1:0] seq;
    logic             to_relay_one;
    logic             final_packet;
    logic             last_of_run;
    logic             all_acked;
  } out_t;

  typedef struct packed {
    op_t              op;
    logic [SEQ_W-1:0] ack_seq;
  } cmd_t;

endpackage

// ===== design/srsw_front.sv =====
module srsw_front (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  srsw_pkg::in_t    in_data,
  output logic             push_valid,
  input  logic             push_ready,
  output srsw_pkg::cmd_t   push_cmd
);

  logic           hold_valid_r;
  logic           hold_valid_nxt;
  srsw_pkg::cmd_t hold_r;
  srsw_pkg::op_t  op;
  logic           accept;

  always_comb begin
    case (in_data.command)
      srsw_pkg::CMD_TICK:  op = srsw_pkg::OP_TICK;
      srsw_pkg::CMD_ACK:   op = srsw_pkg::OP_ACK;
      srsw_pkg::CMD_START: op = srsw_pkg::OP_START;
      default:             op = srsw_pkg::OP_NOP;
    endcase
  end

  assign in_ready   = !hold_valid_r || push_ready;
  assign accept     = in_valid && in_ready;
  assign push_valid = hold_valid_r;
  assign push_cmd   = hold_r;

  // drop unknown commands here
  assign hold_valid_nxt = (hold_valid_r && !push_ready) ||
                          (accept && (op != srsw_pkg::OP_NOP));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_valid_r <= 1'b0;
    end else begin
      hold_valid_r <= hold_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_r.op      <= op;
      hold_r.ack_seq <= in_data.ack_seq;
    end
  end

endmodule

// ===== design/srsw_queue.sv =====
module srsw_queue (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push_valid,
  output logic           push_ready,
  input  srsw_pkg::cmd_t push_cmd,
  output logic           pop_valid,
  input  logic           pop_ready,
  output srsw_pkg::cmd_t pop_cmd
);

  localparam int unsigned PTR_W = (srsw_pkg::Q_DEPTH > 1) ? $clog2(srsw_pkg::Q_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(srsw_pkg::Q_DEPTH + 1);

  srsw_pkg::cmd_t   mem [srsw_pkg::Q_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;
  logic             do_push;
  logic             do_pop;

  assign push_ready = (count_r != CNT_W'(srsw_pkg::Q_DEPTH));
  assign pop_valid  = (count_r != '0);
  assign pop_cmd    = mem[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    count_nxt = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    ptr_inc = (p == PTR_W'(srsw_pkg::Q_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (do_push) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_pop) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

// ===== design/srsw_back.sv =====
module srsw_back (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [srsw_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [srsw_pkg::CFG_W-1:0]         cfg_data,
  input  logic                               pop_valid,
  output logic                               pop_ready,
  input  srsw_pkg::cmd_t                     pop_cmd,
  output logic                               out_valid,
  input  logic                               out_ready,
  output srsw_pkg::out_t                     out_data
);

  localparam int unsigned SW  = srsw_pkg::SLOT_W;
  localparam int unsigned CW  = srsw_pkg::CNT_W;
  localparam int unsigned QW  = srsw_pkg::SEQ_W;
  localparam int unsigned TW  = srsw_pkg::TIME_W;
  localparam int unsigned W   = srsw_pkg::WINDOW;
  localparam int unsigned SW1 = SW + 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_TICK  = 6'b000010,
    ST_SLIDE = 6'b000100,
    ST_START = 6'b001000,
    ST_DRAIN = 6'b010000,
    ST_SPARE = 6'b100000
  } back_state_t;

  typedef struct packed {
    logic          action;
    logic [QW-1:0] seq;
  } res_t;

  back_state_t state_r, state_nxt;
  logic        started_r, started_nxt;
  logic [QW-1:0] base_r, base_nxt;
  logic [QW-1:0] nts_r, nts_nxt;
  logic [QW-1:0] scan_seq_r, scan_seq_nxt;
  logic [SW-1:0] base_slot_r, base_slot_nxt;
  logic [SW-1:0] next_slot_r, next_slot_nxt;
  logic [SW-1:0] scan_slot_r, scan_slot_nxt;
  logic [TW-1:0] time_r, time_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [CW-1:0] rd_r, rd_nxt;
  logic [W-1:0]  acked_r, acked_nxt;
  logic          out_valid_r, out_valid_nxt;
  srsw_pkg::out_t out_r, out_nxt;
  logic [srsw_pkg::CFG_W-1:0] pkt_cnt_r;
  logic [srsw_pkg::CFG_W-1:0] tmo_r;

  logic [TW-1:0] deadline_mem [W];
  res_t          res_mem [W];

  logic          dl_we;
  logic [SW-1:0] dl_wa;
  logic          res_we;
  res_t          res_wd;

  logic [srsw_pkg::CFG_W-1:0] t_eff;
  logic [TW-1:0]  arm_val;
  logic [TW-1:0]  elapsed;
  logic           due;
  logic [QW-1:0]  ack_off;
  logic [SW1-1:0] ack_sum;
  logic [SW1-1:0] ack_slot;
  logic           ack_hit;
  logic           cnt_full;
  logic           last_res;
  res_t           rd_res;

  function automatic logic [SW-1:0] slot_inc(input logic [SW-1:0] s);
    slot_inc = (s == SW'(W - 1)) ? '0 : s + SW'(1);
  endfunction

  assign cfg_ready = 1'b1;
  assign pop_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  assign t_eff    = (tmo_r == '0) ? srsw_pkg::CFG_W'(1) : tmo_r;
  assign arm_val  = time_r + TW'(t_eff);
  assign elapsed  = time_r - deadline_mem[scan_slot_r];
  assign due      = !acked_r[scan_slot_r] && !elapsed[TW-1];
  assign ack_off  = pop_cmd.ack_seq - base_r;
  assign ack_sum  = SW1'(base_slot_r) + SW1'(ack_off[SW-1:0]);
  assign ack_slot = (ack_sum >= SW1'(W)) ? ack_sum - SW1'(W) : ack_sum;
  assign ack_hit  = started_r && (pop_cmd.ack_seq >= base_r) && (pop_cmd.ack_seq < nts_r);
  assign cnt_full = (cnt_r == CW'(W));
  assign last_res = (rd_r == cnt_r - CW'(1));
  assign rd_res   = res_mem[rd_r[SW-1:0]];

  always_comb begin
    state_nxt     = state_r;
    started_nxt   = started_r;
    base_nxt      = base_r;
    nts_nxt       = nts_r;
    scan_seq_nxt  = scan_seq_r;
    base_slot_nxt = base_slot_r;
    next_slot_nxt = next_slot_r;
    scan_slot_nxt = scan_slot_r;
    time_nxt      = time_r;
    cnt_nxt       = cnt_r;
    rd_nxt        = rd_r;
    acked_nxt     = acked_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_nxt       = out_r;
    dl_we         = 1'b0;
    dl_wa         = next_slot_r;
    res_we        = 1'b0;
    res_wd        = '{action: srsw_pkg::ACT_NEW, seq: nts_r};

    case (state_r)
      ST_IDLE: begin
        if (pop_valid) begin
          case (pop_cmd.op)
            srsw_pkg::OP_TICK: begin
              time_nxt = time_r + TW'(1);
              if (started_r) begin
                scan_seq_nxt  = base_r;
                scan_slot_nxt = base_slot_r;
                cnt_nxt       = '0;
                state_nxt     = ST_TICK;
              end
            end
            srsw_pkg::OP_ACK: begin
              if (ack_hit) begin
                acked_nxt[ack_slot[SW-1:0]] = 1'b1;
                cnt_nxt   = '0;
                state_nxt = ST_SLIDE;
              end
            end
            srsw_pkg::OP_START: begin
              if (!started_r) begin
                started_nxt   = 1'b1;
                base_nxt      = '0;
                nts_nxt       = '0;
                base_slot_nxt = '0;
                next_slot_nxt = '0;
                acked_nxt     = '0;
                cnt_nxt       = '0;
                state_nxt     = ST_START;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ST_TICK: begin
        if ((scan_seq_r < nts_r) && !cnt_full) begin
          if (due) begin
            res_we  = 1'b1;
            res_wd  = '{action: srsw_pkg::ACT_RETX, seq: scan_seq_r};
            cnt_nxt = cnt_r + CW'(1);
            dl_we   = 1'b1;
            dl_wa   = scan_slot_r;
          end
          scan_seq_nxt  = scan_seq_r + QW'(1);
          scan_slot_nxt = slot_inc(scan_slot_r);
        end else begin
          rd_nxt    = '0;
          state_nxt = (cnt_r != '0) ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_SLIDE: begin
        if ((base_r < nts_r) && acked_r[base_slot_r] && !cnt_full) begin
          acked_nxt[base_slot_r] = 1'b0;
          base_nxt      = base_r + QW'(1);
          base_slot_nxt = slot_inc(base_slot_r);
          if (nts_r < pkt_cnt_r) begin
            res_we  = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
            acked_nxt[next_slot_r] = 1'b0;
            dl_we         = 1'b1;
            nts_nxt       = nts_r + QW'(1);
            next_slot_nxt = slot_inc(next_slot_r);
          end
        end else begin
          rd_nxt    = '0;
          state_nxt = (cnt_r != '0) ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_START: begin
        if ((nts_r < pkt_cnt_r) && !cnt_full) begin
          res_we  = 1'b1;
          cnt_nxt = cnt_r + CW'(1);
          acked_nxt[next_slot_r] = 1'b0;
          dl_we         = 1'b1;
          nts_nxt       = nts_r + QW'(1);
          next_slot_nxt = slot_inc(next_slot_r);
        end else begin
          rd_nxt    = '0;
          state_nxt = (cnt_r != '0) ? ST_DRAIN : ST_IDLE;
        end
      end
      ST_DRAIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt        = 1'b1;
          out_nxt.action       = rd_res.action;
          out_nxt.seq          = rd_res.seq;
          out_nxt.to_relay_one = rd_res.seq[0];
          out_nxt.final_packet = (pkt_cnt_r != '0) &&
                                 (rd_res.seq == pkt_cnt_r - QW'(1));
          out_nxt.last_of_run  = last_res;
          out_nxt.all_acked    = (base_r >= pkt_cnt_r);
          rd_nxt               = rd_r + CW'(1);
          if (last_res) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      started_r   <= 1'b0;
      base_r      <= '0;
      nts_r       <= '0;
      scan_seq_r  <= '0;
      base_slot_r <= '0;
      next_slot_r <= '0;
      scan_slot_r <= '0;
      time_r      <= '0;
      cnt_r       <= '0;
      rd_r        <= '0;
      acked_r     <= '0;
      out_valid_r <= 1'b0;
      pkt_cnt_r   <= '0;
      tmo_r       <= srsw_pkg::TIMEOUT_RESET;
    end else begin
      state_r     <= state_nxt;
      started_r   <= started_nxt;
      base_r      <= base_nxt;
      nts_r       <= nts_nxt;
      scan_seq_r  <= scan_seq_nxt;
      base_slot_r <= base_slot_nxt;
      next_slot_r <= next_slot_nxt;
      scan_slot_r <= scan_slot_nxt;
      time_r      <= time_nxt;
      cnt_r       <= cnt_nxt;
      rd_r        <= rd_nxt;
      acked_r     <= acked_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          srsw_pkg::CFG_PACKET_COUNT:  pkt_cnt_r <= cfg_data;
          srsw_pkg::CFG_TIMEOUT_TICKS: tmo_r     <= cfg_data;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
    if (dl_we) begin
      deadline_mem[dl_wa] <= arm_val;
    end
    if (res_we) begin
      res_mem[cnt_r[SW-1:0]] <= res_wd;
    end
  end

endmodule

// ===== design/selective_repeat_sender_window.sv =====
// Flow: an input item passes the front hold register and the command queue before the step
// engine takes it; the engine walks one window slot per cycle, then the drain state loads
// its results into the output register, one transfer per cycle while the output is not stalled.
// Throughput: sequential; the step engine takes a new item only when idle, after it has
// loaded the last result into the output register; a stalled output register stalls the drain.
// Reset: synchronous, active low; clears the window, time, acked flags and handshakes,
// sets packet_count to 0 and timeout_ticks to 3; deadline storage is not cleared.
module selective_repeat_sender_window (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  srsw_pkg::in_t                  in_data,
  output logic                           out_valid,
  input  logic                           out_ready,
  output srsw_pkg::out_t                 out_data,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [srsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [srsw_pkg::CFG_W-1:0]     cfg_data
);

  logic           push_valid;
  logic           push_ready;
  srsw_pkg::cmd_t push_cmd;
  logic           pop_valid;
  logic           pop_ready;
  srsw_pkg::cmd_t pop_cmd;

  srsw_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd)
  );

  srsw_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_cmd   (push_cmd),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_cmd    (pop_cmd)
  );

  srsw_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_cmd   (pop_cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== design/srsw_checker.sv =====
`include "selective_repeat_sender_window_macros.svh"

module srsw_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input srsw_pkg::in_t                  in_data,
  input logic                           out_valid,
  input logic                           out_ready,
  input srsw_pkg::out_t                 out_data,
  input logic                           cfg_valid,
  input logic                           cfg_ready,
  input logic [srsw_pkg::CFG_IDX_W-1:0] cfg_index,
  input logic [srsw_pkg::CFG_W-1:0]     cfg_data
);

  `SRSW_ASSERT_ALWAYS(a_reset_idle, clk, !rst_n |=> !out_valid)
  `SRSW_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_data))
  `SRSW_ASSERT(a_relay, clk, rst_n, out_valid |-> out_data.to_relay_one == out_data.seq[0])
  `SRSW_ASSERT(a_run_cont, clk, rst_n, out_valid && out_ready && !out_data.last_of_run |=> out_valid && out_data.all_acked == $past(out_data.all_acked))

endmodule

bind selective_repeat_sender_window srsw_checker u_srsw_checker (.*);
